### hw/rtl/ukfq_pkg.sv
// ----------------------------------------------------------------------------
// ukfq_pkg
// Shared types and constants for the unique-key FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ukfq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_LOAD,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/ukfq_ram.sv
// ----------------------------------------------------------------------------
// ukfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ukfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/unique_key_fifo_queue.sv
// ----------------------------------------------------------------------------
// unique_key_fifo_queue
// Bounded FIFO of key/value pairs that refuses a push of an already queued key.
// ----------------------------------------------------------------------------
// One command is in work at a time; req_stall is high from the transfer until
// its result is loaded into the output register. A push walks the queued
// entries through the single read port of the entry RAM and one shared key
// comparator, one entry per cycle. A pop of a non-empty queue and a valid read
// pass through fetch and load states for the registered RAM read; the rest go
// straight to the finish state. A result waiting in the output register does
// not block the transfer of the next command.
`default_nettype none

module unique_key_fifo_queue #(
    parameter int DEPTH = ukfq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [ukfq_pkg::CMD_W-1:0]    cmd,
    input  wire logic [ukfq_pkg::KEY_W-1:0]    key,
    input  wire logic [ukfq_pkg::VALUE_W-1:0]  value,
    input  wire logic [ukfq_pkg::POS_W-1:0]    position,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [ukfq_pkg::STAT_W-1:0]   status,
    output logic      [ukfq_pkg::KEY_W-1:0]    out_key,
    output logic      [ukfq_pkg::VALUE_W-1:0]  out_value,
    output logic      [ukfq_pkg::COUNT_W-1:0]  count
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = ukfq_pkg::POS_W;
    localparam int CMPW  = (CW > PW) ? CW : PW;
    localparam int KW    = ukfq_pkg::KEY_W;
    localparam int VW    = ukfq_pkg::VALUE_W;
    localparam int RAM_W = KW + VW;

    ukfq_pkg::state_t state_reg, state_next;

    logic [ukfq_pkg::CMD_W-1:0] cmd_reg;
    logic [KW-1:0]              key_reg;
    logic [VW-1:0]              value_reg;
    logic [PW-1:0]              pos_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_pend_reg, cmp_pend_next;

    logic [ukfq_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [KW-1:0]               res_key_reg, res_key_next;
    logic [VW-1:0]               res_value_reg, res_value_next;

    logic                          out_valid_reg, out_valid_next;
    logic [ukfq_pkg::STAT_W-1:0]   out_status_reg;
    logic [KW-1:0]                 out_key_reg;
    logic [VW-1:0]                 out_value_reg;
    logic [ukfq_pkg::COUNT_W-1:0]  out_count_reg;

    logic          accept;
    logic          out_load;
    logic [IW-1:0] offset;
    logic [IW:0]   slot_sum;
    logic [IW-1:0] slot;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [RAM_W-1:0] ram_rd_data;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_value;
    logic [CMPW-1:0] pos_in_ext;
    logic [CMPW-1:0] pos_reg_ext;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] pos_off;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ukfq_pkg::ST_IDLE);

    // circular slot: head + offset modulo DEPTH
    assign slot_sum = {1'b0, head_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
                                                   : slot_sum[IW-1:0];

    assign rd_key   = ram_rd_data[RAM_W-1:VW];
    assign rd_value = ram_rd_data[VW-1:0];

    assign pos_in_ext  = CMPW'(position);
    assign pos_reg_ext = CMPW'(pos_reg);
    assign count_ext   = CMPW'(count_reg);
    assign pos_off     = pos_reg_ext - CMPW'(1);

    ukfq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot),
        .wr_data ({key_reg, value_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_value_next  = res_value_reg;
        offset          = '0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            ukfq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ukfq_pkg::STAT_NONE;
                    res_key_next    = '0;
                    res_value_next  = '0;
                    scan_idx_next   = '0;
                    cmp_pend_next   = 1'b0;
                    state_next      = ukfq_pkg::ST_FINISH;
                    case (cmd)
                        ukfq_pkg::CMD_PUSH:
                        begin
                            state_next = ukfq_pkg::ST_SCAN;
                        end
                        ukfq_pkg::CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ukfq_pkg::ST_FETCH;
                            end
                        end
                        ukfq_pkg::CMD_READ:
                        begin
                            if (position != '0 && pos_in_ext <= count_ext)
                            begin
                                state_next = ukfq_pkg::ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ukfq_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            ukfq_pkg::ST_SCAN:
            begin
                if (cmp_pend_reg && rd_key == key_reg)
                begin
                    res_status_next = ukfq_pkg::STAT_DUP;
                    state_next      = ukfq_pkg::ST_FINISH;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    offset        = IW'(scan_idx_reg);
                    ram_rd_en     = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                    cmp_pend_next = 1'b1;
                end
                else
                begin
                    if (count_reg == CW'(DEPTH))
                    begin
                        res_status_next = ukfq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        offset          = IW'(count_reg);
                        ram_wr_en       = 1'b1;
                        count_next      = count_reg + CW'(1);
                        res_status_next = ukfq_pkg::STAT_OK;
                    end
                    state_next = ukfq_pkg::ST_FINISH;
                end
            end
            ukfq_pkg::ST_FETCH:
            begin
                offset     = (cmd_reg == ukfq_pkg::CMD_POP) ? '0 : IW'(pos_off);
                ram_rd_en  = 1'b1;
                state_next = ukfq_pkg::ST_LOAD;
            end
            ukfq_pkg::ST_LOAD:
            begin
                res_status_next = ukfq_pkg::STAT_OK;
                res_key_next    = rd_key;
                res_value_next  = rd_value;
                if (cmd_reg == ukfq_pkg::CMD_POP)
                begin
                    offset     = IW'(1);
                    head_next  = slot;
                    count_next = count_reg - CW'(1);
                end
                state_next = ukfq_pkg::ST_FINISH;
            end
            ukfq_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ukfq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ukfq_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ukfq_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
            pos_reg   <= position;
        end
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_value_reg  <= res_value_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_key_reg    <= res_key_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= ukfq_pkg::COUNT_W'(count_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_key   = out_key_reg;
    assign out_value = out_value_reg;
    assign count     = out_count_reg;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for unique_key_fifo_queue. A local model of the queue
// predicts one reply per command transfer; a monitor compares every reply
// transfer in order. Directed corner cases come first, then full-queue
// episodes and random traffic under three sender/receiver idle profiles.
// ----------------------------------------------------------------------------
module tb;

    localparam int QDEPTH  = ukfq_pkg::DEPTH_DEFAULT;
    localparam int CMD_W   = ukfq_pkg::CMD_W;
    localparam int KEY_W   = ukfq_pkg::KEY_W;
    localparam int VALUE_W = ukfq_pkg::VALUE_W;
    localparam int POS_W   = ukfq_pkg::POS_W;
    localparam int STAT_W  = ukfq_pkg::STAT_W;
    localparam int COUNT_W = ukfq_pkg::COUNT_W;

    localparam logic [CMD_W-1:0]  CMD_PUSH  = ukfq_pkg::CMD_PUSH;
    localparam logic [CMD_W-1:0]  CMD_POP   = ukfq_pkg::CMD_POP;
    localparam logic [CMD_W-1:0]  CMD_READ  = ukfq_pkg::CMD_READ;
    localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
    localparam logic [STAT_W-1:0] STAT_OK   = ukfq_pkg::STAT_OK;
    localparam logic [STAT_W-1:0] STAT_DUP  = ukfq_pkg::STAT_DUP;
    localparam logic [STAT_W-1:0] STAT_FULL = ukfq_pkg::STAT_FULL;
    localparam logic [STAT_W-1:0] STAT_NONE = ukfq_pkg::STAT_NONE;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   out_key;
        logic [VALUE_W-1:0] out_value;
        logic [COUNT_W-1:0] count;
    } reply_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STAT_W-1:0]   status;
    logic [KEY_W-1:0]    out_key;
    logic [VALUE_W-1:0]  out_value;
    logic [COUNT_W-1:0]  count;

    // queue model
    logic [KEY_W-1:0]   q_keys [QDEPTH];
    logic [VALUE_W-1:0] q_vals [QDEPTH];
    int unsigned        q_head;
    int unsigned        q_len;

    reply_t owed_replies [$];

    int send_idle_pct;
    int rsp_idle_pct;
    int errors;
    int replies_checked;
    int n_push, n_pop, n_read, n_spare;
    int n_dup, n_full, n_none;

    unique_key_fifo_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .key       (key),
        .value     (value),
        .position  (position),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .out_key   (out_key),
        .out_value (out_value),
        .count     (count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    function automatic bit key_is_live(input logic [KEY_W-1:0] k);
        for (int i = 0; i < q_len; i++)
        begin
            if (q_keys[(q_head + i) % QDEPTH] == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] some_live_key();
        return q_keys[(q_head + $urandom_range(q_len - 1)) % QDEPTH];
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do
            k = KEY_W'($urandom);
        while (key_is_live(k));
        return k;
    endfunction

    function automatic reply_t apply_queue_cmd(input logic [CMD_W-1:0]   c,
                                               input logic [KEY_W-1:0]   k,
                                               input logic [VALUE_W-1:0] v,
                                               input logic [POS_W-1:0]   p);
        reply_t      r;
        int unsigned slot;
        r.status    = STAT_NONE;
        r.out_key   = '0;
        r.out_value = '0;
        case (c)
            CMD_PUSH:
            begin
                n_push++;
                if (key_is_live(k))
                    r.status = STAT_DUP;
                else if (q_len >= QDEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    slot = (q_head + q_len) % QDEPTH;
                    q_keys[slot] = k;
                    q_vals[slot] = v;
                    q_len++;
                    r.status = STAT_OK;
                end
            end
            CMD_POP:
            begin
                n_pop++;
                if (q_len != 0)
                begin
                    r.out_key   = q_keys[q_head];
                    r.out_value = q_vals[q_head];
                    q_head      = (q_head + 1) % QDEPTH;
                    q_len--;
                    r.status    = STAT_OK;
                end
            end
            CMD_READ:
            begin
                n_read++;
                if (p != 0 && p <= q_len)
                begin
                    slot        = (q_head + p - 1) % QDEPTH;
                    r.out_key   = q_keys[slot];
                    r.out_value = q_vals[slot];
                    r.status    = STAT_OK;
                end
            end
            default:
                n_spare++;
        endcase
        if (r.status == STAT_DUP)
            n_dup++;
        else if (r.status == STAT_FULL)
            n_full++;
        else if (r.status == STAT_NONE)
            n_none++;
        r.count = COUNT_W'(q_len);
        return r;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0]   c,
                            input logic [KEY_W-1:0]   k,
                            input logic [VALUE_W-1:0] v,
                            input logic [POS_W-1:0]   p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= c;
        key       <= k;
        value     <= v;
        position  <= p;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        owed_replies.push_back(apply_queue_cmd(c, k, v, p));
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_t seen;
        reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            seen = {status, out_key, out_value, count};
            replies_checked++;
            if (owed_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("tb: unexpected reply status %0d key %h value %h count %0d",
                             seen.status, seen.out_key, seen.out_value, seen.count);
            end
            else
            begin
                want = owed_replies.pop_front();
                if (seen.status !== want.status || seen.out_key !== want.out_key ||
                    seen.out_value !== want.out_value || seen.count !== want.count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"tb: mismatch: expected status %0d key %h value %h ",
                                  "count %0d, got status %0d key %h value %h count %0d"},
                                 want.status, want.out_key, want.out_value, want.count,
                                 seen.status, seen.out_key, seen.out_value, seen.count);
                end
            end
        end
    end

    // empty-queue cases, spare command, key extremes, duplicate, read positions
    task automatic test_basic_cmds();
        send_cmd(CMD_POP, '0, '0, '0);
        send_cmd(CMD_READ, '0, '0, 5'd1);
        send_cmd(CMD_SPARE, '1, '1, '1);
        send_cmd(CMD_PUSH, 16'h0000, 16'hFFFF, '0);
        send_cmd(CMD_PUSH, 16'hFFFF, 16'h0000, '1);
        send_cmd(CMD_PUSH, 16'h0000, 16'h1234, 5'd3);
        send_cmd(CMD_READ, '1, '1, 5'd0);
        send_cmd(CMD_READ, '0, '0, 5'd1);
        send_cmd(CMD_READ, '0, '0, 5'd2);
        send_cmd(CMD_READ, '0, '0, 5'd3);
        send_cmd(CMD_READ, '0, '0, 5'd31);
        send_cmd(CMD_POP, '1, '1, '1);
        send_cmd(CMD_POP, '0, '0, '0);
        send_cmd(CMD_POP, '0, '0, '0);
    endtask

    // fill to capacity, refusals at full, duplicate wins over full, drain past empty
    task automatic test_full_queue();
        logic [KEY_W-1:0] gone;
        while (q_len != 0)
            send_cmd(CMD_POP, KEY_W'($urandom), VALUE_W'($urandom), POS_W'($urandom));
        repeat (QDEPTH)
            send_cmd(CMD_PUSH, fresh_key(), VALUE_W'($urandom), POS_W'($urandom));
        send_cmd(CMD_PUSH, fresh_key(), VALUE_W'($urandom), POS_W'($urandom));
        send_cmd(CMD_PUSH, some_live_key(), VALUE_W'($urandom), POS_W'($urandom));
        send_cmd(CMD_READ, KEY_W'($urandom), VALUE_W'($urandom), POS_W'(QDEPTH));
        send_cmd(CMD_READ, KEY_W'($urandom), VALUE_W'($urandom), POS_W'(QDEPTH + 1));
        send_cmd(CMD_READ, KEY_W'($urandom), VALUE_W'($urandom),
                 POS_W'($urandom_range(1, QDEPTH)));
        gone = q_keys[q_head];
        send_cmd(CMD_POP, KEY_W'($urandom), VALUE_W'($urandom), POS_W'($urandom));
        send_cmd(CMD_PUSH, gone, VALUE_W'($urandom), POS_W'($urandom));
        repeat (QDEPTH + 1)
            send_cmd(CMD_POP, KEY_W'($urandom), VALUE_W'($urandom), POS_W'($urandom));
    endtask

    // traffic that swings between filling and draining
    task automatic test_random_mix(input int n_items);
        int               roll;
        int               push_pct;
        logic [CMD_W-1:0] c;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] p;
        for (int i = 0; i < n_items; i++)
        begin
            push_pct = ((i / 40) % 2) ? 25 : 60;
            roll = $urandom_range(99);
            if (roll < push_pct)
                c = CMD_PUSH;
            else if (roll < push_pct + 20)
                c = CMD_POP;
            else if (roll < 96)
                c = CMD_READ;
            else
                c = CMD_SPARE;
            roll = $urandom_range(99);
            if (roll < 30 && q_len != 0)
                k = some_live_key();
            else if (roll < 55)
                k = KEY_W'($urandom_range(31));
            else
                k = KEY_W'($urandom);
            if ($urandom_range(3) == 0)
                p = POS_W'($urandom);
            else
                p = POS_W'($urandom_range(q_len + 1));
            send_cmd(c, k, VALUE_W'($urandom), p);
        end
    endtask

    initial
    begin : timeout_guard
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin : run_tests
        int guard;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        cmd           = '0;
        key           = '0;
        value         = '0;
        position      = '0;
        rsp_stall     = 1'b0;
        q_head        = 0;
        q_len         = 0;
        send_idle_pct = 23;
        rsp_idle_pct  = 60;
        errors        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_cmds();
        test_full_queue();
        test_random_mix(590);

        send_idle_pct = 60;
        rsp_idle_pct <= 23;
        test_full_queue();
        test_random_mix(590);

        send_idle_pct = 0;
        rsp_idle_pct <= 0;
        test_full_queue();
        test_random_mix(590);

        req_valid <= 1'b0;
        guard = 0;
        while (owed_replies.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (QDEPTH + 8) @(posedge clk);
        if (owed_replies.size() != 0)
        begin
            errors += owed_replies.size();
            $display("tb: %0d replies never arrived", owed_replies.size());
        end

        $display("tb: %0d commands (push %0d, pop %0d, read %0d, spare %0d), %0d replies checked",
                 n_push + n_pop + n_read + n_spare, n_push, n_pop, n_read, n_spare,
                 replies_checked);
        $display("tb: refused as duplicate %0d, as full %0d, empty or not found %0d, errors %0d",
                 n_dup, n_full, n_none, errors);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
